[rtl/core/vrb_pkg.sv]
// shared constants, types and command/status structs for the voxel ray walker
package vrb_pkg;

  localparam int GRID_SIZE  = 16;
  localparam int BLOCK_BITS = 8;
  localparam int COORD_W    = $clog2(GRID_SIZE);
  localparam int CELL_AW    = 3 * COORD_W;
  localparam int CELLS      = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AXES       = 3;
  localparam int POS_W      = COORD_W + 2;
  localparam int DIST_W     = COORD_W + 1;
  localparam int MAG_W      = 16;
  localparam int NUM_W      = 9;
  localparam int PROD_W     = 29;
  localparam int NPROD      = 6;
  localparam int MIDX_W     = 3;
  localparam int MAXD_W     = 4;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // cross products n_a * |d_b|
  localparam logic [MIDX_W-1:0] P_XY = 3'd0;
  localparam logic [MIDX_W-1:0] P_YX = 3'd1;
  localparam logic [MIDX_W-1:0] P_XZ = 3'd2;
  localparam logic [MIDX_W-1:0] P_ZX = 3'd3;
  localparam logic [MIDX_W-1:0] P_YZ = 3'd4;
  localparam logic [MIDX_W-1:0] P_ZY = 3'd5;

  localparam logic [0:0] REG_MAX_DISTANCE = 1'b0;
  localparam logic [0:0] REG_AIR_CODE     = 1'b1;

  localparam logic [MAXD_W-1:0]     MAXD_RESET = 4'd5;
  localparam logic [BLOCK_BITS-1:0] AIR_RESET  = '0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RAY   = 1'b1;

  typedef struct packed {
    logic               load;
    logic               wr_cell;
    logic               mul_en;
    logic [MIDX_W-1:0]  mul_idx;
    logic               step_en;
    logic               clr_we;
    logic [CELL_AW-1:0] clr_addr;
    logic               hit_we;
    logic               res_clear;
    logic               out_load;
  } cmd_t;

  typedef struct packed {
    logic exceed;
    logic next_in_grid;
    logic solid;
  } sts_t;

endpackage

[rtl/core/vrb_ram.sv]
// generic single write port ram with registered read
module vrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/vrb_regs.sv]
// apb configuration registers: max_distance and air_code
module vrb_regs import vrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  output logic [MAXD_W-1:0]     max_distance,
  output logic [BLOCK_BITS-1:0] air_code
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= MAXD_RESET;
      air_code     <= AIR_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_MAX_DISTANCE: max_distance <= pwdata[MAXD_W-1:0];
        REG_AIR_CODE:     air_code     <= pwdata[BLOCK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_DISTANCE: prdata = {{(APB_DW-MAXD_W){1'b0}}, max_distance};
      REG_AIR_CODE:     prdata = {{(APB_DW-BLOCK_BITS){1'b0}}, air_code};
      default:          prdata = '0;
    endcase
  end

endmodule

[rtl/core/vrb_ctrl.sv]
// sequencer: grid clear, setup multiplies, dda step and cell check, result handoff
module vrb_ctrl import vrb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic op,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_STEP  = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t             state, state_next;
  logic [CELL_AW-1:0] clr_cnt;
  logic [MIDX_W-1:0]  mul_idx;
  logic               out_free;

  assign out_free = ~out_valid | out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.clr_addr = clr_cnt;
    cmd.mul_idx  = mul_idx;
    state_next   = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (&clr_cnt) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (op == OP_WRITE) begin
            cmd.wr_cell   = 1'b1;
            cmd.res_clear = 1'b1;
            state_next    = S_DONE;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (mul_idx == P_ZY) state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step_en = 1'b1;
        if (sts.exceed) begin
          cmd.res_clear = 1'b1;
          state_next    = S_DONE;
        end else if (sts.next_in_grid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.solid) begin
          cmd.hit_we = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_STEP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      mul_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.clr_we) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.load) mul_idx <= P_XY;
      else if (cmd.mul_en) mul_idx <= mul_idx + 1'b1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

[rtl/core/vrb_dp.sv]
// datapath: axis setup, cross products, dda step, grid ram and result registers
module vrb_dp import vrb_pkg::*; (
  input  logic                  clk,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [MAXD_W-1:0]     max_distance,
  input  logic [BLOCK_BITS-1:0] air_code,
  input  logic [COORD_W-1:0]    cell_x,
  input  logic [COORD_W-1:0]    cell_y,
  input  logic [COORD_W-1:0]    cell_z,
  input  logic [BLOCK_BITS-1:0] block_value,
  input  logic [11:0]           origin_x,
  input  logic [11:0]           origin_y,
  input  logic [11:0]           origin_z,
  input  logic signed [15:0]    dir_x,
  input  logic signed [15:0]    dir_y,
  input  logic signed [15:0]    dir_z,
  output logic                  hit,
  output logic [COORD_W-1:0]    hit_x,
  output logic [COORD_W-1:0]    hit_y,
  output logic [COORD_W-1:0]    hit_z,
  output logic [BLOCK_BITS-1:0] removed_block
);

  logic [11:0]         org     [AXES];
  logic [15:0]         dir     [AXES];
  logic [MAG_W-1:0]    mag     [AXES];
  logic [NUM_W-1:0]    num0    [AXES];
  logic                neg     [AXES];
  logic                inf     [AXES];
  logic [POS_W-1:0]    pos     [AXES];
  logic [POS_W-1:0]    pos_nxt [AXES];
  logic [DIST_W-1:0]   walk_dist [AXES];
  logic [PROD_W-1:0]   prod    [NPROD];
  logic [NUM_W-1:0]    mul_a;
  logic [MAG_W-1:0]    mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic                lt_xy, lt_xz, lt_yz;
  logic [1:0]          step_ax;
  logic [DIST_W-1:0]   dist_sel;
  logic [DIST_W-1:0]   dist_inc;
  logic                ram_we;
  logic [CELL_AW-1:0]  ram_waddr, ram_raddr, cur_addr;
  logic [BLOCK_BITS-1:0] ram_wdata, ram_rdata;
  logic                res_hit;
  logic [COORD_W-1:0]  res_x, res_y, res_z;
  logic [BLOCK_BITS-1:0] res_block;

  always_comb begin
    org[0] = origin_x; org[1] = origin_y; org[2] = origin_z;
    dir[0] = dir_x;    dir[1] = dir_y;    dir[2] = dir_z;
  end

  // setup multiplies, one product per cycle
  always_comb begin
    case (cmd.mul_idx)
      P_XY:    begin mul_a = num0[0]; mul_b = mag[1]; end
      P_YX:    begin mul_a = num0[1]; mul_b = mag[0]; end
      P_XZ:    begin mul_a = num0[0]; mul_b = mag[2]; end
      P_ZX:    begin mul_a = num0[2]; mul_b = mag[0]; end
      P_YZ:    begin mul_a = num0[1]; mul_b = mag[2]; end
      P_ZY:    begin mul_a = num0[2]; mul_b = mag[1]; end
      default: begin mul_a = '0;      mul_b = '0;     end
    endcase
    mul_p = PROD_W'(mul_a * mul_b);
  end

  // crossing time compares and axis choice
  assign lt_xy = ~inf[0] & (inf[1] | (prod[P_XY] < prod[P_YX]));
  assign lt_xz = ~inf[0] & (inf[2] | (prod[P_XZ] < prod[P_ZX]));
  assign lt_yz = ~inf[1] & (inf[2] | (prod[P_YZ] < prod[P_ZY]));

  always_comb begin
    if (lt_xy) step_ax = lt_xz ? AX_X : AX_Z;
    else       step_ax = lt_yz ? AX_Y : AX_Z;
    dist_sel = '0;
    for (int i = 0; i < AXES; i++) begin
      if (step_ax == 2'(i)) begin
        pos_nxt[i] = neg[i] ? pos[i] - 1'b1 : pos[i] + 1'b1;
        dist_sel   = walk_dist[i];
      end else begin
        pos_nxt[i] = pos[i];
      end
    end
    dist_inc = dist_sel + 1'b1;
  end

  assign sts.exceed       = dist_inc > {1'b0, max_distance};
  assign sts.next_in_grid = (pos_nxt[0][POS_W-1:COORD_W] == '0) &&
                            (pos_nxt[1][POS_W-1:COORD_W] == '0) &&
                            (pos_nxt[2][POS_W-1:COORD_W] == '0);
  assign sts.solid        = ram_rdata != air_code;

  assign ram_raddr = {pos_nxt[0][COORD_W-1:0], pos_nxt[1][COORD_W-1:0],
                      pos_nxt[2][COORD_W-1:0]};
  assign cur_addr  = {pos[0][COORD_W-1:0], pos[1][COORD_W-1:0], pos[2][COORD_W-1:0]};

  always_comb begin
    ram_we    = cmd.clr_we | cmd.wr_cell | cmd.hit_we;
    ram_waddr = cur_addr;
    ram_wdata = air_code;
    if (cmd.clr_we) begin
      ram_waddr = cmd.clr_addr;
      ram_wdata = '0;
    end else if (cmd.wr_cell) begin
      ram_waddr = {cell_x, cell_y, cell_z};
      ram_wdata = block_value;
    end
  end

  vrb_ram #(.WIDTH(BLOCK_BITS), .DEPTH(CELLS)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < AXES; i++) begin
        neg[i]  <= dir[i][15];
        inf[i]  <= dir[i] == '0;
        mag[i]  <= dir[i][15] ? MAG_W'(17'h10000 - {1'b0, dir[i]}) : dir[i];
        num0[i] <= dir[i][15] ? {1'b0, org[i][7:0]} : NUM_W'(9'd256 - {1'b0, org[i][7:0]});
        pos[i]  <= {2'b00, org[i][11:8]};
        walk_dist[i] <= '0;
      end
    end
    if (cmd.mul_en) prod[cmd.mul_idx] <= mul_p;
    if (cmd.step_en) begin
      for (int i = 0; i < AXES; i++) begin
        pos[i] <= pos_nxt[i];
        if (step_ax == 2'(i)) walk_dist[i] <= dist_inc;
      end
      // each step on an axis adds 256 to its boundary distance
      case (step_ax)
        AX_X: begin
          prod[P_XY] <= prod[P_XY] + PROD_W'({mag[1], 8'h00});
          prod[P_XZ] <= prod[P_XZ] + PROD_W'({mag[2], 8'h00});
        end
        AX_Y: begin
          prod[P_YX] <= prod[P_YX] + PROD_W'({mag[0], 8'h00});
          prod[P_YZ] <= prod[P_YZ] + PROD_W'({mag[2], 8'h00});
        end
        AX_Z: begin
          prod[P_ZX] <= prod[P_ZX] + PROD_W'({mag[0], 8'h00});
          prod[P_ZY] <= prod[P_ZY] + PROD_W'({mag[1], 8'h00});
        end
        default: ;
      endcase
    end
    if (cmd.res_clear) begin
      res_hit <= 1'b0; res_x <= '0; res_y <= '0; res_z <= '0; res_block <= '0;
    end else if (cmd.hit_we) begin
      res_hit   <= 1'b1;
      res_x     <= pos[0][COORD_W-1:0];
      res_y     <= pos[1][COORD_W-1:0];
      res_z     <= pos[2][COORD_W-1:0];
      res_block <= ram_rdata;
    end
    if (cmd.out_load) begin
      hit <= res_hit; hit_x <= res_x; hit_y <= res_y; hit_z <= res_z;
      removed_block <= res_block;
    end
  end

endmodule

[rtl/core/voxel_ray_break.sv]
// top level of the voxel ray walker: grid store, dda ray cast and cell removal
//
// usage: the input channel (in_valid/in_ready) takes one transaction per item.
// op selects a cell write (cell_x/y/z, block_value) or a ray cast (origin_*,
// dir_*). every item gives exactly one transaction on the output channel
// (out_valid/out_ready): a write reports all zero, a ray reports the first
// solid cell along it (cleared to air in the grid) or a miss with all zero.
// sequence: a write goes from accept straight to the result handoff. a ray
// is accepted, forms its 6 setup products on the shared multiplier, then
// walks dda steps (a step state, plus a grid ram read and check state when
// the cell is in the grid), at most 3*max_distance+1 steps, then hands its
// result off. one item is processed at a time, and the next is taken while
// a result still waits.
// reset: registers go to max_distance 5, air_code 0, and the grid ram is
// swept to zero across all 4096 cells, during which in_ready stays low
// (apb writes are taken throughout). a stalled receiver holds the result in
// the output register; the block stops only once a second result is ready.
module voxel_ray_break import vrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [COORD_W-1:0]    cell_x,
  input  logic [COORD_W-1:0]    cell_y,
  input  logic [COORD_W-1:0]    cell_z,
  input  logic [BLOCK_BITS-1:0] block_value,
  input  logic [11:0]           origin_x,
  input  logic [11:0]           origin_y,
  input  logic [11:0]           origin_z,
  input  logic signed [15:0]    dir_x,
  input  logic signed [15:0]    dir_y,
  input  logic signed [15:0]    dir_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [COORD_W-1:0]    hit_x,
  output logic [COORD_W-1:0]    hit_y,
  output logic [COORD_W-1:0]    hit_z,
  output logic [BLOCK_BITS-1:0] removed_block
);

  logic [MAXD_W-1:0]     max_distance;
  logic [BLOCK_BITS-1:0] air_code;
  cmd_t                  cmd;
  sts_t                  sts;

  // configuration registers
  vrb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_distance (max_distance),
    .air_code     (air_code)
  );

  // sequencer owns handshakes, clear sweep and step loop
  vrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: exact time compares via cross products kept up to date by adds
  vrb_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .max_distance  (max_distance),
    .air_code      (air_code),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .cell_z        (cell_z),
    .block_value   (block_value),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .origin_z      (origin_z),
    .dir_x         (dir_x),
    .dir_y         (dir_y),
    .dir_z         (dir_z),
    .hit           (hit),
    .hit_x         (hit_x),
    .hit_y         (hit_y),
    .hit_z         (hit_z),
    .removed_block (removed_block)
  );

endmodule
